FILE: rtl/core/wtrs_pkg.sv
// Shared types, constants and helpers for the wavelet tree range rank/select unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package wtrs_pkg;

   localparam int N_MAX     = 1024;
   localparam int IDX_W     = 10;
   localparam int CNT_W     = 11;
   localparam int VAL_W     = 16;
   localparam int LEVELS    = 16;
   localparam int LVL_W     = 4;
   localparam int QD_W      = 5;
   localparam int ROW_LEN   = N_MAX + 1;
   localparam int TBL_DEPTH = LEVELS * ROW_LEN;
   localparam int TBL_AW    = 15;
   localparam int CSR_IW    = 2;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_COUNT = 2'd1;
   localparam logic [1:0] FUNC_KTH   = 2'd2;

   localparam logic [CSR_IW-1:0] CSR_VALUE_LOW  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_VALUE_HIGH = 2'd1;

   localparam logic [LVL_W-1:0] LVL_LAST = 4'd15;

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [VAL_W-1:0] lo;
      logic [VAL_W-1:0] hi;
   } elem_type;

   typedef struct packed {
      logic accept;
      logic sat_wr;
      logic lvl_start;
      logic p1_ex;
      logic p2_ex;
      logic q_head;
      logic q_rd;
      logic q_calc;
   } cmd_type;

   typedef struct packed {
      logic idx_last;
      logic node_split;
      logic node_end;
      logic row_end;
      logic lvl_last;
      logic q_term;
      logic q_rd_done;
      logic q_direct;
   } status_type;

   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [CNT_W-1:0] pos);
      tbl_addr = {1'b0, lvl, 10'b0} + {11'b0, lvl} + {4'b0, pos};
   endfunction

endpackage

FILE: rtl/core/wtrs_ctrl.sv
// Sequencing state machine for loads, the tree build and the query walk.
// Depends on wtrs_pkg; drives the datapath by command and reads its status.
module wtrs_ctrl import wtrs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_func,
   input  logic       req_element_last,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_SAT_RD = 11'b00000000010,
      S_SAT_WR = 11'b00000000100,
      S_LVL    = 11'b00000001000,
      S_P1_RD  = 11'b00000010000,
      S_P1_EX  = 11'b00000100000,
      S_P2_RD  = 11'b00001000000,
      S_P2_EX  = 11'b00010000000,
      S_Q_HEAD = 11'b00100000000,
      S_Q_RD   = 11'b01000000000,
      S_Q_CALC = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               if (req_func == FUNC_LOAD) begin
                  if (req_element_last) state_in = S_SAT_RD;
               end else if (req_func == FUNC_COUNT || req_func == FUNC_KTH) begin
                  if (!status.q_direct) state_in = S_Q_HEAD;
               end
            end
         end
         S_SAT_RD: state_in = S_SAT_WR;
         S_SAT_WR: begin
            cmd.sat_wr = 1'b1;
            state_in = status.idx_last ? S_LVL : S_SAT_RD;
         end
         S_LVL: begin
            cmd.lvl_start = 1'b1;
            state_in = S_P1_RD;
         end
         S_P1_RD: state_in = S_P1_EX;
         S_P1_EX: begin
            cmd.p1_ex = 1'b1;
            state_in = (status.node_split || status.idx_last) ? S_P2_RD : S_P1_RD;
         end
         S_P2_RD: state_in = S_P2_EX;
         S_P2_EX: begin
            cmd.p2_ex = 1'b1;
            if (status.node_end) begin
               if (status.row_end) begin
                  state_in = status.lvl_last ? S_IDLE : S_LVL;
               end else begin
                  state_in = S_P1_RD;
               end
            end else begin
               state_in = S_P2_RD;
            end
         end
         S_Q_HEAD: begin
            cmd.q_head = 1'b1;
            state_in = status.q_term ? S_IDLE : S_Q_RD;
         end
         S_Q_RD: begin
            cmd.q_rd = 1'b1;
            if (status.q_rd_done) state_in = S_Q_CALC;
         end
         S_Q_CALC: begin
            cmd.q_calc = 1'b1;
            state_in = S_Q_HEAD;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/wtrs_datapath.sv
// Value buffers, prefix count table, build and query registers, and result register.
// Depends on wtrs_pkg; acts on commands from wtrs_ctrl and returns status to it.
module wtrs_datapath import wtrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [1:0]        req_func,
   input  logic [VAL_W-1:0]  req_element_value,
   input  logic              req_element_last,
   input  logic [IDX_W-1:0]  req_query_left,
   input  logic [IDX_W-1:0]  req_query_right,
   input  logic [VAL_W-1:0]  req_query_k,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [VAL_W-1:0]  csr_data,
   output logic              rsp_valid,
   output logic [VAL_W-1:0]  rsp_answer,
   output logic              rsp_invalid
);

   elem_type buf0_mem [N_MAX];
   elem_type buf1_mem [N_MAX];
   logic [CNT_W-1:0] tbl_mem [TBL_DEPTH];
   elem_type buf0_rd_ff, buf1_rd_ff;
   logic [CNT_W-1:0] tbl_rd_ff;

   logic [CNT_W-1:0] count_ff, count_in, idx_ff, idx_in, s_ff, s_in, e_ff, e_in;
   logic [CNT_W-1:0] o_ff, o_in, prefix_ff, prefix_in;
   logic             ready_ff, ready_in;
   logic [VAL_W-1:0] tlo_ff, tlo_in, thi_ff, thi_in, vlow_ff, vhigh_ff;
   logic [VAL_W-1:0] nlo_ff, nlo_in, nhi_ff, nhi_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   logic [CNT_W-1:0] qa_ff, qa_in, qb_ff, qb_in, qs_ff, qs_in, qsize_ff, qsize_in;
   logic [CNT_W-1:0] qacc_ff, qacc_in, base_ff, base_in, ra_ff, ra_in;
   logic [CNT_W-1:0] rb_ff, rb_in, rs_ff, rs_in;
   logic [VAL_W-1:0] qk_ff, qk_in, qlo_ff, qlo_in, qhi_ff, qhi_in;
   logic [QD_W-1:0]  qd_ff, qd_in;
   logic [2:0]       qj_ff, qj_in;
   logic             kth_ff, kth_in;

   logic             rvalid_ff, rvalid_in, rbad_ff, rbad_in;
   logic [VAL_W-1:0] rans_ff, rans_in;

   logic             we0, we1, tbl_we;
   logic [IDX_W-1:0] wa0, wa1;
   elem_type         wd0, wd1, cur, nxt_el, sat_el;
   logic [TBL_AW-1:0] tbl_waddr, tbl_raddr;
   logic [CNT_W-1:0] tbl_wdata, cnt_eff, qpos, pa, pb, lt, diff, span;
   logic [VAL_W-1:0] elo, ehi, emid, qmid, tl, th, v;
   logic             go_left, first, is_kth, bad, cterm1, cterm2, kterm;

   always_ff @(posedge clock) begin
      if (we0) buf0_mem[wa0] <= wd0;
      if (we1) buf1_mem[wa1] <= wd1;
      if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
      buf0_rd_ff <= buf0_mem[idx_ff[IDX_W-1:0]];
      buf1_rd_ff <= buf1_mem[idx_ff[IDX_W-1:0]];
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ready_ff  <= 1'b0;
         tlo_ff    <= '0;
         thi_ff    <= '0;
         vlow_ff   <= '0;
         vhigh_ff  <= 16'hFFFF;
         rvalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ready_ff  <= ready_in;
         tlo_ff    <= tlo_in;
         thi_ff    <= thi_in;
         rvalid_ff <= rvalid_in;
         if (csr_we && csr_index == CSR_VALUE_LOW) vlow_ff <= csr_data;
         if (csr_we && csr_index == CSR_VALUE_HIGH) vhigh_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;  s_ff <= s_in;  e_ff <= e_in;  o_ff <= o_in;
      prefix_ff <= prefix_in;  nlo_ff <= nlo_in;  nhi_ff <= nhi_in;  lvl_ff <= lvl_in;
      qa_ff <= qa_in;  qb_ff <= qb_in;  qs_ff <= qs_in;  qsize_ff <= qsize_in;
      qacc_ff <= qacc_in;  base_ff <= base_in;  ra_ff <= ra_in;  rb_ff <= rb_in;
      rs_ff <= rs_in;  qk_ff <= qk_in;  qlo_ff <= qlo_in;  qhi_ff <= qhi_in;
      qd_ff <= qd_in;  qj_ff <= qj_in;  kth_ff <= kth_in;
      rbad_ff <= rbad_in;  rans_ff <= rans_in;
   end

   assign rsp_valid   = rvalid_ff;
   assign rsp_answer  = rans_ff;
   assign rsp_invalid = rbad_ff;

   always_comb begin
      cur = lvl_ff[0] ? buf1_rd_ff : buf0_rd_ff;
      first = (idx_ff == s_ff);
      elo = (cmd.p1_ex && first) ? cur.lo : nlo_ff;
      ehi = (cmd.p1_ex && first) ? cur.hi : nhi_ff;
      emid = elo + ((ehi - elo) >> 1);
      go_left = (elo == ehi) || (cur.value <= emid);
      nxt_el.value = cur.value;
      nxt_el.lo = go_left ? elo : emid + 16'd1;
      nxt_el.hi = go_left ? emid : ehi;

      tl = vlow_ff;
      th = (vhigh_ff < vlow_ff) ? vlow_ff : vhigh_ff;
      v = buf0_rd_ff.value;
      if (v < tlo_ff) v = tlo_ff;
      if (v > thi_ff) v = thi_ff;
      sat_el.value = v;
      sat_el.lo = tlo_ff;
      sat_el.hi = thi_ff;

      cnt_eff = ready_ff ? '0 : count_ff;
      is_kth = (req_func == FUNC_KTH);
      span = {1'b0, req_query_right} - {1'b0, req_query_left} + 11'd1;
      bad = !ready_ff || ({1'b0, req_query_left} >= count_ff) ||
            ({1'b0, req_query_right} >= count_ff) ||
            (is_kth && ((req_query_left > req_query_right) || (req_query_k == '0) ||
                        (req_query_k > {5'b0, span})));

      cterm1 = (qa_ff >= qb_ff) || (qk_ff < qlo_ff);
      cterm2 = (qhi_ff <= qk_ff);
      kterm = (qlo_ff >= qhi_ff);

      case (qj_ff)
         3'd0:    qpos = qs_ff;
         3'd1:    qpos = qs_ff + qa_ff;
         3'd2:    qpos = qs_ff + qb_ff;
         default: qpos = qs_ff + qsize_ff;
      endcase
      tbl_raddr = tbl_addr(qd_ff[LVL_W-1:0], qpos);

      pa = ra_ff - base_ff;
      pb = rb_ff - base_ff;
      lt = rs_ff - base_ff;
      diff = pb - pa;
      qmid = qlo_ff + ((qhi_ff - qlo_ff) >> 1);

      status.idx_last   = (idx_ff == count_ff - 11'd1);
      status.node_split = !first && (cur.lo != nlo_ff);
      status.node_end   = (idx_ff + 11'd1 == e_ff);
      status.row_end    = (e_ff == count_ff);
      status.lvl_last   = (lvl_ff == LVL_LAST);
      status.q_term     = qd_ff[QD_W-1] || (kth_ff ? kterm : (cterm1 || cterm2));
      status.q_rd_done  = (qj_ff == 3'd4);
      status.q_direct   = bad || (!is_kth && (req_query_left > req_query_right));
   end

   always_comb begin
      count_in = count_ff;  ready_in = ready_ff;  tlo_in = tlo_ff;  thi_in = thi_ff;
      idx_in = idx_ff;  s_in = s_ff;  e_in = e_ff;  o_in = o_ff;  prefix_in = prefix_ff;
      nlo_in = nlo_ff;  nhi_in = nhi_ff;  lvl_in = lvl_ff;
      qa_in = qa_ff;  qb_in = qb_ff;  qs_in = qs_ff;  qsize_in = qsize_ff;
      qacc_in = qacc_ff;  base_in = base_ff;  ra_in = ra_ff;  rb_in = rb_ff;
      rs_in = rs_ff;  qk_in = qk_ff;  qlo_in = qlo_ff;  qhi_in = qhi_ff;
      qd_in = qd_ff;  qj_in = qj_ff;  kth_in = kth_ff;
      rvalid_in = 1'b0;  rbad_in = rbad_ff;  rans_in = rans_ff;
      we0 = 1'b0;  we1 = 1'b0;  wa0 = o_ff[IDX_W-1:0];  wa1 = o_ff[IDX_W-1:0];
      wd0 = nxt_el;  wd1 = nxt_el;
      tbl_we = 1'b0;  tbl_waddr = tbl_addr(lvl_ff, idx_ff + 11'd1);
      tbl_wdata = prefix_ff + {10'b0, go_left};

      if (cmd.accept) begin
         if (req_func == FUNC_LOAD) begin
            ready_in = 1'b0;
            count_in = cnt_eff;
            if (cnt_eff < 11'(N_MAX)) begin
               we0 = 1'b1;
               wa0 = cnt_eff[IDX_W-1:0];
               wd0.value = req_element_value;
               wd0.lo = '0;
               wd0.hi = '0;
               count_in = cnt_eff + 11'd1;
            end
            if (req_element_last) begin
               tlo_in = tl;
               thi_in = th;
               idx_in = '0;
               lvl_in = '0;
            end
         end else if (req_func == FUNC_COUNT || req_func == FUNC_KTH) begin
            if (status.q_direct) begin
               rvalid_in = 1'b1;
               rbad_in = bad;
               rans_in = '0;
            end
            qa_in = {1'b0, req_query_left};
            qb_in = {1'b0, req_query_right} + 11'd1;
            qk_in = req_query_k;
            qlo_in = tlo_ff;
            qhi_in = thi_ff;
            qs_in = '0;
            qsize_in = count_ff;
            qacc_in = '0;
            qd_in = '0;
            qj_in = '0;
            kth_in = is_kth;
         end
      end

      if (cmd.sat_wr) begin
         we0 = 1'b1;
         wa0 = idx_ff[IDX_W-1:0];
         wd0 = sat_el;
         idx_in = idx_ff + 11'd1;
      end

      if (cmd.lvl_start) begin
         tbl_we = 1'b1;
         tbl_waddr = tbl_addr(lvl_ff, '0);
         tbl_wdata = '0;
         prefix_in = '0;
         idx_in = '0;
         s_in = '0;
         o_in = '0;
      end

      if (cmd.p1_ex) begin
         if (status.node_split) begin
            e_in = idx_ff;
            idx_in = s_ff;
         end else begin
            if (first) begin
               nlo_in = cur.lo;
               nhi_in = cur.hi;
            end
            tbl_we = 1'b1;
            prefix_in = tbl_wdata;
            if (go_left) begin
               we0 = lvl_ff[0];
               we1 = !lvl_ff[0];
               o_in = o_ff + 11'd1;
            end
            if (status.idx_last) begin
               e_in = count_ff;
               idx_in = s_ff;
            end else begin
               idx_in = idx_ff + 11'd1;
            end
         end
      end

      if (cmd.p2_ex) begin
         if (!go_left) begin
            we0 = lvl_ff[0];
            we1 = !lvl_ff[0];
            o_in = o_ff + 11'd1;
         end
         idx_in = idx_ff + 11'd1;
         if (status.node_end) begin
            s_in = e_ff;
            idx_in = e_ff;
            if (status.row_end) begin
               lvl_in = lvl_ff + 4'd1;
               if (status.lvl_last) ready_in = 1'b1;
            end
         end
      end

      if (cmd.q_head && status.q_term) begin
         rvalid_in = 1'b1;
         rbad_in = 1'b0;
         if (kth_ff) begin
            rans_in = qlo_ff;
         end else if (!cterm1 && cterm2) begin
            rans_in = {5'b0, qacc_ff + qb_ff - qa_ff};
         end else begin
            rans_in = {5'b0, qacc_ff};
         end
      end

      if (cmd.q_rd) begin
         case (qj_ff)
            3'd1:    base_in = tbl_rd_ff;
            3'd2:    ra_in = tbl_rd_ff;
            3'd3:    rb_in = tbl_rd_ff;
            3'd4:    rs_in = tbl_rd_ff;
            default: base_in = base_ff;
         endcase
         qj_in = status.q_rd_done ? 3'd0 : qj_ff + 3'd1;
      end

      if (cmd.q_calc) begin
         qd_in = qd_ff + 5'd1;
         if (kth_ff ? (qk_ff <= {5'b0, diff}) : (qk_ff <= qmid)) begin
            qa_in = pa;
            qb_in = pb;
            qsize_in = lt;
            qhi_in = qmid;
         end else begin
            if (kth_ff) qk_in = qk_ff - {5'b0, diff};
            else qacc_in = qacc_ff + diff;
            qa_in = qa_ff - pa;
            qb_in = qb_ff - pb;
            qs_in = qs_ff + lt;
            qsize_in = qsize_ff - lt;
            qlo_in = qmid + 16'd1;
         end
      end
   end

endmodule

FILE: rtl/core/wavelet_tree_range_rank_select_unit.sv
// Top level of the wavelet tree range count and range k-th smallest unit.
// Depends on wtrs_pkg, wtrs_ctrl and wtrs_datapath.
//
// Usage: a command is taken on a rising edge with start high and busy low.
// Function load writes one element; the element marked last starts the build,
// which first saturates all N loaded values into the range and then builds 16
// levels, each by a two-pass stable split over the single-port value buffers.
// Busy stays high during the build.
// A count or k-th query walks up to 16 levels; each level makes four reads from
// the single read port of the prefix count table. Rejected queries are answered
// in the cycle after they are taken.
// Each result is shown on rsp_answer and rsp_invalid for one cycle with rsp_valid
// high; the receiver cannot stall, so no result waits. Function code 3 is taken
// and gives no result. Configuration writes on the csr channel are always ready
// and should be made while busy is low. Reset clears the element count and the
// tree-built flag and restores the range registers; memories keep their contents.
module wavelet_tree_range_rank_select_unit import wtrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_func,
   input  logic [VAL_W-1:0]  req_element_value,
   input  logic              req_element_last,
   input  logic [IDX_W-1:0]  req_query_left,
   input  logic [IDX_W-1:0]  req_query_right,
   input  logic [VAL_W-1:0]  req_query_k,
   output logic              rsp_valid,
   output logic [VAL_W-1:0]  rsp_answer,
   output logic              rsp_invalid,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [VAL_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   wtrs_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_func         (req_func),
      .req_element_last (req_element_last),
      .status           (status),
      .cmd              (cmd),
      .busy             (busy)
   );

   wtrs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_element_value (req_element_value),
      .req_element_last  (req_element_last),
      .req_query_left    (req_query_left),
      .req_query_right   (req_query_right),
      .req_query_k       (req_query_k),
      .csr_we            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_answer        (rsp_answer),
      .rsp_invalid       (rsp_invalid)
   );

endmodule
